// ----- hw/rtl/load_cell_median_weigher_defines.svh -----
// Assertion macros for the load-cell median weigher.
`ifndef LOAD_CELL_MEDIAN_WEIGHER_DEFINES_SVH
`define LOAD_CELL_MEDIAN_WEIGHER_DEFINES_SVH
`ifndef SYNTHESIS
// Property checked on every rising clk_i edge while out of reset
`define LCMW_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// Condition that must never hold
`define LCMW_ASSERT_NEVER(label, cond, msg) \
  `LCMW_ASSERT(label, !(cond), msg)
`else
`define LCMW_ASSERT(label, prop, msg)
`define LCMW_ASSERT_NEVER(label, cond, msg)
`endif
`endif

// ----- hw/rtl/lcmw_pkg.sv -----
// Shared widths, constants and control types of the load-cell median weigher.
package lcmw_pkg;

  // Field widths
  localparam int RAW_W    = 24;
  localparam int CNT_W    = 20;
  localparam int TARE_W   = 18;
  localparam int GAIN_W   = 18;
  localparam int WEIGHT_W = 23;
  localparam int MAX_LANES = 3;

  // Sign flip turns the two's complement sample into offset binary
  localparam logic [RAW_W-1:0] SIGN_FLIP = 24'h800000;

  // Divide by 100 as multiply by ceil(2^31/100), exact for all 24-bit inputs
  localparam int DIV_RECIP_W = 25;
  localparam logic [DIV_RECIP_W-1:0] DIV_RECIP = 25'd21474837;
  localparam int DIV_SHIFT  = 31;
  localparam int DIV_PROD_W = RAW_W + DIV_RECIP_W;

  // Q16 gains
  localparam int Q_SHIFT = 16;
  localparam logic [WEIGHT_W-1:0] WEIGHT_MAX = 23'h7FFFFF;

  // Configuration register map
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_TARE0    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TARE1    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TARE2    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_REF_GAIN = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_OUT_GAIN = 3'd4;

  localparam logic [GAIN_W-1:0] REF_GAIN_RST = 18'd181743;
  localparam logic [GAIN_W-1:0] OUT_GAIN_RST = 18'd109227;

  // Sequencer strobes into each lane
  typedef struct packed {
    logic div_en;     // raw word taken, divide product captured
    logic scale_en;   // tare compare and gain product captured
    logic store_en;   // count shifted into the window
    logic scan_en;    // one median candidate tested, window rotated
    logic acc_en;     // median added into the round sum
    logic acc_first;  // first round of a set: load instead of add
  } lane_ctrl_t;

  // Sequencer strobes into the merge stage
  typedef struct packed {
    logic mul_en;   // output gain products captured
    logic load_en;  // saturated weights loaded into the output register
  } merge_ctrl_t;

endpackage

// ----- hw/rtl/lcmw_lane.sv -----
// One lane: offset/divide, tare and gain scaling, count window, median scan, round sum.
module lcmw_lane #(
  parameter int WINDOW = 7,
  parameter int SUM_W  = 21
) (
  input  logic                       clk_i,
  input  lcmw_pkg::lane_ctrl_t       ctrl_i,
  input  logic [lcmw_pkg::RAW_W-1:0]  raw_i,
  input  logic [lcmw_pkg::TARE_W-1:0] tare_i,
  input  logic [lcmw_pkg::GAIN_W-1:0] ref_gain_i,
  output logic [SUM_W-1:0]           sum_o
);
  import lcmw_pkg::*;

  localparam int K      = WINDOW / 2;
  localparam int RANK_W = $clog2(WINDOW + 1);
  localparam int SCL_W  = TARE_W + GAIN_W;

  logic [DIV_PROD_W-1:0] div_prod_q;
  logic [TARE_W-1:0]     quot;
  logic [TARE_W-1:0]     diff;
  logic [SCL_W-1:0]      scl_prod_q;
  logic                  above_q;
  logic [CNT_W-1:0]      count;
  logic [CNT_W-1:0]      win_q [WINDOW];
  logic [RANK_W-1:0]     n_lt;
  logic [RANK_W-1:0]     n_le;
  logic                  is_median;
  logic [CNT_W-1:0]      med_q;
  logic [SUM_W-1:0]      sum_q;

  // Stage 1: flip sign, multiply by reciprocal of 100
  always_ff @(posedge clk_i) begin
    if (ctrl_i.div_en) begin
      div_prod_q <= DIV_PROD_W'(raw_i ^ SIGN_FLIP) * DIV_PROD_W'(DIV_RECIP);
    end
  end

  assign quot = div_prod_q[DIV_SHIFT +: TARE_W];
  assign diff = quot - tare_i;

  // Stage 2: strict tare compare, tared value times reference gain
  always_ff @(posedge clk_i) begin
    if (ctrl_i.scale_en) begin
      above_q    <= quot > tare_i;
      scl_prod_q <= SCL_W'(diff) * SCL_W'(ref_gain_i);
    end
  end

  // Q16 truncation; the product always fits the count width
  assign count = above_q ? scl_prod_q[Q_SHIFT +: CNT_W] : '0;

  // Window shift line; rotates during the median scan so tap 0 is the candidate
  always_ff @(posedge clk_i) begin
    if (ctrl_i.store_en) begin
      win_q[0] <= count;
      for (int i = 1; i < WINDOW; i++) begin
        win_q[i] <= win_q[i-1];
      end
    end else if (ctrl_i.scan_en) begin
      win_q[0] <= win_q[WINDOW-1];
      for (int i = 1; i < WINDOW; i++) begin
        win_q[i] <= win_q[i-1];
      end
    end
  end

  // Rank of the candidate against the whole window
  always_comb begin
    n_lt = '0;
    n_le = '0;
    for (int j = 0; j < WINDOW; j++) begin
      n_lt = n_lt + RANK_W'(win_q[j] < win_q[0]);
      n_le = n_le + RANK_W'(win_q[j] <= win_q[0]);
    end
  end

  // Candidate sits at sorted position K when ties straddle it
  assign is_median = (n_lt <= RANK_W'(K)) && (n_le > RANK_W'(K));

  always_ff @(posedge clk_i) begin
    if (ctrl_i.scan_en && is_median) begin
      med_q <= win_q[0];
    end
  end

  // Sum of medians over the rounds of one output set
  always_ff @(posedge clk_i) begin
    if (ctrl_i.acc_en) begin
      sum_q <= ctrl_i.acc_first ? SUM_W'(med_q) : sum_q + SUM_W'(med_q);
    end
  end

  assign sum_o = sum_q;

endmodule

// ----- hw/rtl/lcmw_merge.sv -----
// Merge stage: output gain per lane, saturation, and the output word register.
module lcmw_merge #(
  parameter int SUM_W = 21
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  lcmw_pkg::merge_ctrl_t        ctrl_i,
  input  logic [SUM_W-1:0]             sum_i [lcmw_pkg::MAX_LANES],
  input  logic [lcmw_pkg::GAIN_W-1:0]   out_gain_i,
  input  logic                         out_ready_i,
  output logic                         out_valid_o,
  output logic [lcmw_pkg::WEIGHT_W-1:0] weight_o [lcmw_pkg::MAX_LANES]
);
  import lcmw_pkg::*;

  localparam int PROD_W = SUM_W + GAIN_W;
  localparam int SH_W   = PROD_W - Q_SHIFT;
  localparam int EXT_W  = (SH_W > WEIGHT_W) ? SH_W : WEIGHT_W;

  logic [PROD_W-1:0]   prod_q   [MAX_LANES];
  logic [WEIGHT_W-1:0] sat      [MAX_LANES];
  logic [WEIGHT_W-1:0] weight_q [MAX_LANES];
  logic                out_valid_q;

  // Output gain products
  always_ff @(posedge clk_i) begin
    if (ctrl_i.mul_en) begin
      for (int l = 0; l < MAX_LANES; l++) begin
        prod_q[l] <= PROD_W'(sum_i[l]) * PROD_W'(out_gain_i);
      end
    end
  end

  // Q16 truncation with saturation at the weight range
  always_comb begin
    for (int l = 0; l < MAX_LANES; l++) begin
      if (EXT_W'(prod_q[l][Q_SHIFT +: SH_W]) > EXT_W'(WEIGHT_MAX)) begin
        sat[l] = WEIGHT_MAX;
      end else begin
        sat[l] = WEIGHT_W'(prod_q[l][Q_SHIFT +: SH_W]);
      end
    end
  end

  // Output word register
  always_ff @(posedge clk_i) begin
    if (ctrl_i.load_en) begin
      weight_q <= sat;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctrl_i.load_en) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign weight_o    = weight_q;

endmodule

// ----- hw/rtl/load_cell_median_weigher.sv -----
// A word completing an output set shows valid after divide, scale, store, median scan, sum,
// gain and load, in that order; the load waits while an unaccepted weight word is held.
// Input words are taken only in idle, so a new word waits out the scale and store states;
// a window end adds the median scan and sum, an output set the gain and load states.
// Reset: asynchronous active low; clears sequencer, indexes and output valid,
// loads register defaults. Count window and median sums are not reset.
`include "load_cell_median_weigher_defines.svh"

module load_cell_median_weigher #(
  parameter int WINDOW = 7,
  parameter int ROUNDS = 2,
  parameter int LANES  = 3
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // Configuration write channel
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [lcmw_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [lcmw_pkg::GAIN_W-1:0]    cfg_data_i,
  // Sample channel
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [lcmw_pkg::RAW_W-1:0]     raw_lane0_i,
  input  logic [lcmw_pkg::RAW_W-1:0]     raw_lane1_i,
  input  logic [lcmw_pkg::RAW_W-1:0]     raw_lane2_i,
  // Weight channel
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [lcmw_pkg::WEIGHT_W-1:0]  weight_lane0_o,
  output logic [lcmw_pkg::WEIGHT_W-1:0]  weight_lane1_o,
  output logic [lcmw_pkg::WEIGHT_W-1:0]  weight_lane2_o
);
  import lcmw_pkg::*;

  localparam int ACT_LANES = (LANES < MAX_LANES) ? LANES : MAX_LANES;
  localparam int IDX_W     = $clog2(WINDOW);
  localparam int RND_W     = (ROUNDS > 1) ? $clog2(ROUNDS) : 1;
  localparam int SUM_W     = CNT_W + $clog2(ROUNDS);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCALE,
    S_STORE,
    S_SCAN,
    S_ACC,
    S_MUL,
    S_LOAD
  } state_e;

  state_e            state_q, state_d;
  logic [IDX_W-1:0]  sample_idx_q, sample_idx_d;
  logic [IDX_W-1:0]  scan_cnt_q, scan_cnt_d;
  logic [RND_W-1:0]  round_q, round_d;

  logic [TARE_W-1:0] tare_q [MAX_LANES];
  logic [GAIN_W-1:0] ref_gain_q;
  logic [GAIN_W-1:0] out_gain_q;

  logic [RAW_W-1:0]    raw    [MAX_LANES];
  logic [SUM_W-1:0]    sum    [MAX_LANES];
  logic [WEIGHT_W-1:0] weight [MAX_LANES];

  lane_ctrl_t  lane_ctrl;
  merge_ctrl_t merge_ctrl;
  logic        in_accept;

  // Configuration registers; writes are always taken
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int l = 0; l < MAX_LANES; l++) begin
        tare_q[l] <= '0;
      end
      ref_gain_q <= REF_GAIN_RST;
      out_gain_q <= OUT_GAIN_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_TARE0:    tare_q[0]  <= cfg_data_i;
        CFG_TARE1:    tare_q[1]  <= cfg_data_i;
        CFG_TARE2:    tare_q[2]  <= cfg_data_i;
        CFG_REF_GAIN: ref_gain_q <= cfg_data_i;
        CFG_OUT_GAIN: out_gain_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Sequencer
  assign in_ready_o = (state_q == S_IDLE);
  assign in_accept  = in_valid_i && in_ready_o;

  always_comb begin
    state_d      = state_q;
    sample_idx_d = sample_idx_q;
    scan_cnt_d   = scan_cnt_q;
    round_d      = round_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          state_d = S_SCALE;
        end
      end
      S_SCALE: state_d = S_STORE;
      S_STORE: begin
        if (sample_idx_q == IDX_W'(WINDOW - 1)) begin
          sample_idx_d = '0;
          scan_cnt_d   = '0;
          state_d      = S_SCAN;
        end else begin
          sample_idx_d = sample_idx_q + 1'b1;
          state_d      = S_IDLE;
        end
      end
      S_SCAN: begin
        if (scan_cnt_q == IDX_W'(WINDOW - 1)) begin
          state_d = S_ACC;
        end else begin
          scan_cnt_d = scan_cnt_q + 1'b1;
        end
      end
      S_ACC: begin
        if (round_q == RND_W'(ROUNDS - 1)) begin
          round_d = '0;
          state_d = S_MUL;
        end else begin
          round_d = round_q + 1'b1;
          state_d = S_IDLE;
        end
      end
      S_MUL: state_d = S_LOAD;
      S_LOAD: begin
        if (!out_valid_o || out_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      sample_idx_q <= '0;
      scan_cnt_q   <= '0;
      round_q      <= '0;
    end else begin
      state_q      <= state_d;
      sample_idx_q <= sample_idx_d;
      scan_cnt_q   <= scan_cnt_d;
      round_q      <= round_d;
    end
  end

  // Strobes to lanes and merge stage
  always_comb begin
    lane_ctrl.div_en    = in_accept;
    lane_ctrl.scale_en  = (state_q == S_SCALE);
    lane_ctrl.store_en  = (state_q == S_STORE);
    lane_ctrl.scan_en   = (state_q == S_SCAN);
    lane_ctrl.acc_en    = (state_q == S_ACC);
    lane_ctrl.acc_first = (round_q == '0);
    merge_ctrl.mul_en   = (state_q == S_MUL);
    merge_ctrl.load_en  = (state_q == S_LOAD) && (!out_valid_o || out_ready_i);
  end

  // Lanes
  assign raw[0] = raw_lane0_i;
  assign raw[1] = raw_lane1_i;
  assign raw[2] = raw_lane2_i;

  for (genvar l = 0; l < MAX_LANES; l++) begin : g_lane
    if (l < ACT_LANES) begin : g_on
      lcmw_lane #(
        .WINDOW (WINDOW),
        .SUM_W  (SUM_W)
      ) u_lane (
        .clk_i      (clk_i),
        .ctrl_i     (lane_ctrl),
        .raw_i      (raw[l]),
        .tare_i     (tare_q[l]),
        .ref_gain_i (ref_gain_q),
        .sum_o      (sum[l])
      );
    end else begin : g_off
      // Unused lane weighs zero
      assign sum[l] = '0;
    end
  end

  lcmw_merge #(
    .SUM_W (SUM_W)
  ) u_merge (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (merge_ctrl),
    .sum_i       (sum),
    .out_gain_i  (out_gain_q),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .weight_o    (weight)
  );

  assign weight_lane0_o = weight[0];
  assign weight_lane1_o = weight[1];
  assign weight_lane2_o = weight[2];

  // Checks
  `LCMW_ASSERT(a_valid_from_load, $rose(out_valid_o) |-> $past(state_q == S_LOAD), "valid without load")
  `LCMW_ASSERT(a_scan_at_wrap, (state_q == S_SCAN) |-> (sample_idx_q == '0), "scan off window end")
  `LCMW_ASSERT(a_accept_to_scale, in_accept |=> (state_q == S_SCALE), "accept not followed by scale")
  `LCMW_ASSERT_NEVER(a_round_range, round_q > RND_W'(ROUNDS - 1), "round index out of range")

endmodule

// ----- dv/load_cell_median_weigher_test.sv -----
// Self-checking testbench: random and edge-case sample words, weights checked in order.
module load_cell_median_weigher_test;
  timeunit 1ns;
  timeprecision 1ps;

  import lcmw_pkg::*;

  typedef logic [MAX_LANES-1:0][RAW_W-1:0]    raw_set_t;
  typedef logic [MAX_LANES-1:0][WEIGHT_W-1:0] weight_set_t;

  // Weight predictor plus in-order compare against the block's weight words
  class weigh_scoreboard #(int WINDOW = 7, int ROUNDS = 2);
    localparam longint unsigned COUNT_LIMIT  = (64'd1 << CNT_W) - 1;
    localparam longint unsigned WEIGHT_LIMIT = (64'd1 << WEIGHT_W) - 1;

    logic [TARE_W-1:0] tare [MAX_LANES];
    logic [GAIN_W-1:0] ref_gain;
    logic [GAIN_W-1:0] out_gain;
    logic [CNT_W-1:0]  counts [MAX_LANES][WINDOW];
    longint unsigned   median_sum [MAX_LANES];
    int unsigned       slot;
    int unsigned       round_idx;
    weight_set_t       expected_q [$];
    int unsigned       fail_cnt;
    int unsigned       shown;

    function new();
      foreach (tare[l]) tare[l] = '0;
      ref_gain  = REF_GAIN_RST;
      out_gain  = OUT_GAIN_RST;
      foreach (median_sum[l]) median_sum[l] = 0;
      slot      = 0;
      round_idx = 0;
      fail_cnt  = 0;
      shown     = 0;
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    // Register write; spare indexes do nothing
    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [GAIN_W-1:0] data);
      case (idx)
        CFG_TARE0:    tare[0] = data;
        CFG_TARE1:    tare[1] = data;
        CFG_TARE2:    tare[2] = data;
        CFG_REF_GAIN: ref_gain = data;
        CFG_OUT_GAIN: out_gain = data;
        default: ;
      endcase
    endfunction

    // Offset binary, /100, strict tare compare, Q16 reference gain
    function logic [CNT_W-1:0] lane_count(logic [RAW_W-1:0] raw, logic [TARE_W-1:0] tare_lvl);
      longint unsigned lvl;
      longint unsigned prod;
      lvl = longint'(raw ^ SIGN_FLIP) / 100;
      if (lvl <= tare_lvl) return '0;
      prod = ((lvl - tare_lvl) * ref_gain) >> Q_SHIFT;
      if (prod > COUNT_LIMIT) prod = COUNT_LIMIT;
      return CNT_W'(prod);
    endfunction

    // Middle entry of the window sorted ascending
    function logic [CNT_W-1:0] window_median(int lane);
      logic [CNT_W-1:0] sorted [WINDOW];
      logic [CNT_W-1:0] x;
      int k;
      for (int i = 0; i < WINDOW; i++) begin
        x = counts[lane][i];
        k = i;
        while (k > 0 && sorted[k-1] > x) begin
          sorted[k] = sorted[k-1];
          k--;
        end
        sorted[k] = x;
      end
      return sorted[WINDOW/2];
    endfunction

    // Accepted sample word: update window, maybe queue a weight word
    function void note_sample(raw_set_t raw);
      logic [CNT_W-1:0] med [MAX_LANES];
      longint unsigned  sum;
      longint unsigned  w;
      weight_set_t      weights;
      for (int l = 0; l < MAX_LANES; l++) counts[l][slot] = lane_count(raw[l], tare[l]);
      slot++;
      if (slot < WINDOW) return;
      slot = 0;
      for (int l = 0; l < MAX_LANES; l++) med[l] = window_median(l);
      if (round_idx + 1 < ROUNDS) begin
        for (int l = 0; l < MAX_LANES; l++)
          median_sum[l] = (round_idx == 0) ? med[l] : median_sum[l] + med[l];
        round_idx++;
        return;
      end
      for (int l = 0; l < MAX_LANES; l++) begin
        sum = med[l];
        if (round_idx > 0) sum += median_sum[l];
        w = (sum * out_gain) >> Q_SHIFT;
        if (w > WEIGHT_LIMIT) w = WEIGHT_LIMIT;
        weights[l] = WEIGHT_W'(w);
      end
      expected_q.push_back(weights);
      round_idx = 0;
    endfunction

    // Accepted weight word against the oldest prediction
    function void check_weight(weight_set_t got);
      weight_set_t want;
      if (expected_q.size() == 0) begin
        fail_cnt++;
        if (shown < 10) begin
          shown++;
          $display("unexpected weight word: lanes 0x%06h 0x%06h 0x%06h",
                   got[0], got[1], got[2]);
        end
        return;
      end
      want = expected_q.pop_front();
      for (int l = 0; l < MAX_LANES; l++) begin
        if (got[l] !== want[l]) begin
          fail_cnt++;
          if (shown < 10) begin
            shown++;
            $display("weight lane %0d: expected 0x%06h, got 0x%06h", l, want[l], got[l]);
          end
        end
      end
    endfunction
  endclass

  localparam int WINDOW = 7;
  localparam int ROUNDS = 2;
  localparam int LANES  = 3;

  localparam int          CLK_PERIOD   = 10;
  localparam int          RESET_CYCLES = 8;
  // pipeline depth plus a median scan and merge, with margin
  localparam int          SETTLE_CYCLES = 40;
  localparam int          PHASES        = 8;
  localparam int          PHASE_ITEMS   = 200;
  localparam int          BLOCK_ITEMS   = 40;
  localparam int unsigned CYCLE_LIMIT   = 600_000;
  localparam int          LEVEL_MAX     = 167772;
  localparam int          TARE_TOP      = (1 << TARE_W) - 1;
  localparam int          GAIN_TOP      = (1 << GAIN_W) - 1;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = CFG_OUT_GAIN + CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = '1;

  // sign/zero/max codes, tare edge levels, alternating bit patterns
  localparam int EDGE_CNT = 10;
  localparam logic [RAW_W-1:0] EDGE_RAW [EDGE_CNT] = '{
    24'h800000, 24'h7FFFFF, 24'hFFFFFF, 24'h000000, 24'h800063,
    24'h800064, 24'h8000C8, 24'h55AAAA, 24'hAA5555, 24'h7FFF9C
  };

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [GAIN_W-1:0]    cfg_data_i = '0;
  logic                 in_valid_i = 1'b0;
  logic                 in_ready_o;
  logic [RAW_W-1:0]     raw_lane0_i = '0;
  logic [RAW_W-1:0]     raw_lane1_i = '0;
  logic [RAW_W-1:0]     raw_lane2_i = '0;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  logic [WEIGHT_W-1:0]  weight_lane0_o;
  logic [WEIGHT_W-1:0]  weight_lane1_o;
  logic [WEIGHT_W-1:0]  weight_lane2_o;

  logic        idle_on = 1'b1;
  logic        stall_on = 1'b1;
  int unsigned ready_hold = 0;
  int unsigned cycle_cnt = 0;

  weigh_scoreboard #(.WINDOW(WINDOW), .ROUNDS(ROUNDS)) sb;

  load_cell_median_weigher #(
    .WINDOW(WINDOW),
    .ROUNDS(ROUNDS),
    .LANES (LANES)
  ) u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .raw_lane0_i   (raw_lane0_i),
    .raw_lane1_i   (raw_lane1_i),
    .raw_lane2_i   (raw_lane2_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .weight_lane0_o(weight_lane0_o),
    .weight_lane1_o(weight_lane1_o),
    .weight_lane2_o(weight_lane2_o)
  );

  always #(CLK_PERIOD/2) clk_i = ~clk_i;

  // Mostly short gaps, now and then a long one
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 19);
    if (r < 8) return 0;
    if (r < 17) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Raw code whose level after the divide is the given one, random remainder
  function automatic logic [RAW_W-1:0] raw_at_level(int level);
    longint unsigned code;
    if (level < 0) level = 0;
    code = longint'(level) * 100 + $urandom_range(0, 99);
    if (code > 64'hFFFFFF) code = 64'hFFFFFF;
    return RAW_W'(code) ^ SIGN_FLIP;
  endfunction

  // Weight side back-pressure
  always @(posedge clk_i) begin
    if (ready_hold != 0) begin
      ready_hold <= ready_hold - 1;
    end else if (!stall_on || $urandom_range(0, 2) != 0) begin
      out_ready_i <= 1'b1;
      ready_hold  <= $urandom_range(0, 6);
    end else begin
      out_ready_i <= 1'b0;
      ready_hold  <= pick_gap();
    end
  end

  // Weight word monitor
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i)
      sb.check_weight({weight_lane2_o, weight_lane1_o, weight_lane0_o});
  end

  // Run-away guard
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // One sample word; valid stays up on return so back-to-back words need no toggle
  task automatic send_sample(input raw_set_t raw);
    int unsigned gap;
    gap = idle_on ? pick_gap() : 0;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    raw_lane0_i <= raw[0];
    raw_lane1_i <= raw[1];
    raw_lane2_i <= raw[2];
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_sample(raw);
  endtask

  // One register word; caller lowers valid after the last one
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [GAIN_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.set_reg(idx, data);
  endtask

  // All five registers plus one write to an unmapped index
  task automatic program_regs(input logic [TARE_W-1:0] t0, input logic [TARE_W-1:0] t1,
                              input logic [TARE_W-1:0] t2, input logic [GAIN_W-1:0] rg,
                              input logic [GAIN_W-1:0] og);
    write_reg(CFG_IDX_W'($urandom_range(CFG_SPARE_LO, CFG_SPARE_HI)),
              GAIN_W'($urandom()));
    write_reg(CFG_TARE0, t0);
    write_reg(CFG_TARE1, t1);
    write_reg(CFG_TARE2, t2);
    write_reg(CFG_REF_GAIN, rg);
    write_reg(CFG_OUT_GAIN, og);
    cfg_valid_i <= 1'b0;
  endtask

  // Drop valid, wait for all weights, then let the pipeline empty
  task automatic drain_and_settle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  initial begin
    raw_set_t          raw;
    logic [TARE_W-1:0] t [MAX_LANES];
    logic [GAIN_W-1:0] rg;
    logic [GAIN_W-1:0] og;
    int                steady [MAX_LANES];
    int unsigned       sel;

    sb = new();
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Edge codes at reset defaults: zero tare, one full output set
    for (int i = 0; i < 2 * WINDOW; i++) begin
      for (int l = 0; l < MAX_LANES; l++) raw[l] = EDGE_RAW[(i + 3 * l) % EDGE_CNT];
      send_sample(raw);
    end
    drain_and_settle();

    // Tare at the top level, above every level, and one below; gains at maximum
    program_regs(TARE_W'(LEVEL_MAX), TARE_W'(TARE_TOP), TARE_W'(LEVEL_MAX - 1),
                 GAIN_W'(GAIN_TOP), GAIN_W'(GAIN_TOP));
    for (int i = 0; i < 2 * WINDOW; i++) begin
      for (int l = 0; l < MAX_LANES; l++)
        raw[l] = (i % 3 == 2) ? EDGE_RAW[(i + l) % EDGE_CNT] : 24'h7FFFFF;
      send_sample(raw);
    end

    // Random phases, each with its own register setting
    for (int p = 0; p < PHASES; p++) begin
      drain_and_settle();
      for (int l = 0; l < MAX_LANES; l++)
        t[l] = ($urandom_range(0, 3) == 0) ? TARE_W'($urandom()) :
                                              TARE_W'($urandom_range(0, 120000));
      rg = GAIN_W'($urandom());
      og = GAIN_W'($urandom());
      case (p)
        0: begin
          foreach (t[l]) t[l] = '0;
          rg = GAIN_W'(GAIN_TOP);
          og = GAIN_W'(GAIN_TOP);
        end
        1: t[0] = TARE_W'(LEVEL_MAX);
        2: begin
          t[2] = TARE_W'(TARE_TOP);
          rg   = '0;
        end
        3: og = '0;
        default: ;
      endcase
      program_regs(t[0], t[1], t[2], rg, og);
      for (int l = 0; l < MAX_LANES; l++)
        steady[l] = int'(sb.tare[l]) + int'($urandom_range(0, 30000));

      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (i % BLOCK_ITEMS == 0) begin
          idle_on  = ($urandom_range(0, 3) != 0);
          stall_on <= ($urandom_range(0, 3) != 0);
        end
        // full-range codes, codes around the tare, and a noisy steady load
        for (int l = 0; l < MAX_LANES; l++) begin
          sel = $urandom_range(0, 9);
          if (sel < 4)
            raw[l] = RAW_W'($urandom());
          else if (sel < 7)
            raw[l] = raw_at_level(int'(sb.tare[l]) + int'($urandom_range(0, 2)) - 1);
          else
            raw[l] = raw_at_level(steady[l] + int'($urandom_range(0, 40)) - 20);
        end
        send_sample(raw);
      end
    end

    drain_and_settle();
    if (sb.fail_cnt == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
